// ===== hdl/tpts_pkg.sv =====
// Package for the timed priority task scheduler.
// Holds beat structs, entry and wave types, status codes and state encoding.
// No dependencies.
package tpts_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned TASK_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned HELD_W   = 5;

    localparam logic [TIME_W-1:0] NOW_LIMIT   = 32'd1;
    localparam logic [TIME_W-1:0] DELAY_LIMIT = 32'd1000;

    typedef enum logic [0:0] {
        MODE_INSERT   = 1'b0,
        MODE_DISPATCH = 1'b1
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED   = 2'd0,
        STAT_DISPATCHED = 2'd1,
        STAT_IDLE       = 2'd2,
        STAT_FULL       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_START,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              mode;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] priority_req;
        logic [TIME_W-1:0] delay_code;
        logic [TIME_W-1:0] now_ms;
        logic              in_window;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TASK_W-1:0]   chosen_task;
        logic [HELD_W-1:0]   entries_held;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [PRIO_W-1:0] prio;
        logic [TASK_W-1:0] task_id;
    } entry_t;

    typedef struct packed {
        logic              ins;
        logic              rmv;
        logic [TIME_W-1:0] now;
        entry_t            new_ent;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic              open;
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [TASK_W-1:0] task_id;
    } wave_t;

endpackage

// ===== hdl/tpts_cell.sv =====
// One slot of the scheduler chain: holds one entry and one stage of the dispatch wave.
// Depends on tpts_pkg.
module tpts_cell #(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned INDEX       = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
    input  tpts_pkg::cmd_t                     cmd,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]     sel_idx,
    input  tpts_pkg::entry_t                   left_ent,
    input  tpts_pkg::entry_t                   right_ent,
    input  logic                               left_place,
    input  tpts_pkg::wave_t                    wave_in,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]     wave_idx_in,
    output tpts_pkg::entry_t                   ent,
    output logic                               place,
    output tpts_pkg::wave_t                    wave_out,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     wave_idx_out
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW = $clog2(QUEUE_DEPTH);

    tpts_pkg::entry_t        ent_reg;
    tpts_pkg::entry_t        ent_next;
    tpts_pkg::wave_t         wave_reg;
    tpts_pkg::wave_t         wave_next;
    logic [IW-1:0]           idx_reg;
    logic [IW-1:0]           idx_next;
    logic                    occupied;
    logic                    due_now;
    logic                    take;

    assign occupied = CW'(INDEX) < count;
    assign due_now  = ent_reg.due <= cmd.now;

    always_comb
    begin
        if (occupied)
        begin
            place = (cmd.new_ent.due < ent_reg.due) ||
                    ((cmd.new_ent.due == ent_reg.due) && (cmd.new_ent.prio > ent_reg.prio));
        end
        else
        begin
            place = 1'b1;
        end
    end

    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.ins && place)
        begin
            ent_next = left_place ? left_ent : cmd.new_ent;
        end
        else if (cmd.rmv && (IW'(INDEX) >= sel_idx))
        begin
            ent_next = right_ent;
        end
    end

    always_comb
    begin
        take = wave_in.valid && wave_in.open && occupied && due_now &&
               (!wave_in.found || (ent_reg.prio > wave_in.prio));
        wave_next.valid   = wave_in.valid;
        wave_next.open    = wave_in.open && occupied && due_now;
        wave_next.found   = wave_in.found || take;
        wave_next.prio    = take ? ent_reg.prio : wave_in.prio;
        wave_next.task_id = take ? ent_reg.task_id : wave_in.task_id;
        idx_next          = take ? IW'(INDEX) : wave_idx_in;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
        end
    end

    assign ent          = ent_reg;
    assign wave_out     = wave_reg;
    assign wave_idx_out = idx_reg;

endmodule

// ===== hdl/timed_priority_task_scheduler_top.sv =====
// Top level of the timed priority task scheduler: control sequencer and chain of slots.
// Depends on tpts_pkg and tpts_cell.
//
// Usage:
//   The request channel (req_valid, req_stall, req) carries one beat per command:
//   insert a task with a delay code, or dispatch the best due task. The response
//   channel (rsp_valid, rsp_stall, rsp) returns exactly one beat per request, in order.
//   The table is a row of QUEUE_DEPTH slots kept sorted by due time, then priority.
//   Insert: every slot compares the new entry at once and shifts right in one step;
//   the request is latched on acceptance, the shift happens in ST_INSERT and the
//   response is then registered; the next request is taken only back in ST_IDLE.
//   Dispatch: a selection wave travels from slot to slot, one slot per cycle, carrying
//   the best due priority seen so far; the winning slot is removed by a one-step left
//   shift. ST_START launches the wave, and the response is registered only after the
//   wave has passed the register of every slot, so the wave length sets dispatch time.
//   req_stall is high while a command is in progress. A finished response sits in the
//   output register while the next request is accepted; if that register is still
//   stalled when the next response is ready, the block holds until it drains.
//   Reset empties the table; slot contents are not cleared and are never read unwritten.
module timed_priority_task_scheduler_top #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  tpts_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tpts_pkg::rsp_t  rsp
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW = $clog2(QUEUE_DEPTH);

    tpts_pkg::state_t                 state_reg;
    tpts_pkg::state_t                 state_next;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [tpts_pkg::TIME_W-1:0]      due_reg;
    logic [tpts_pkg::TIME_W-1:0]      due_next;
    logic [tpts_pkg::PRIO_W-1:0]      prio_reg;
    logic [tpts_pkg::PRIO_W-1:0]      prio_next;
    logic [tpts_pkg::TASK_W-1:0]      task_reg;
    logic [tpts_pkg::TASK_W-1:0]      task_next;
    logic [tpts_pkg::TIME_W-1:0]      now_reg;
    logic [tpts_pkg::TIME_W-1:0]      now_next;
    logic                             win_reg;
    logic                             win_next;
    tpts_pkg::rsp_t                   res_reg;
    tpts_pkg::rsp_t                   res_next;
    tpts_pkg::rsp_t                   rsp_reg;
    tpts_pkg::rsp_t                   rsp_next;
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;

    logic                             accept;
    logic                             rsp_free;
    logic                             fin;
    tpts_pkg::rsp_t                   fin_res;
    logic [tpts_pkg::TIME_W-1:0]      resolved_due;
    tpts_pkg::cmd_t                   cmd;
    logic [IW-1:0]                    sel_idx;
    tpts_pkg::wave_t                  wave_start;

    tpts_pkg::entry_t                 ent      [QUEUE_DEPTH];
    tpts_pkg::entry_t                 left_e   [QUEUE_DEPTH];
    tpts_pkg::entry_t                 right_e  [QUEUE_DEPTH];
    logic                             place    [QUEUE_DEPTH];
    logic                             left_p   [QUEUE_DEPTH];
    tpts_pkg::wave_t                  wave     [QUEUE_DEPTH+1];
    logic [IW-1:0]                    wave_idx [QUEUE_DEPTH+1];

    assign accept    = req_valid && !req_stall;
    assign req_stall = state_reg != tpts_pkg::ST_IDLE;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        if (req.delay_code <= tpts_pkg::NOW_LIMIT)
        begin
            resolved_due = req.now_ms;
        end
        else if (req.delay_code <= tpts_pkg::DELAY_LIMIT)
        begin
            resolved_due = req.now_ms + req.delay_code;
        end
        else
        begin
            resolved_due = (req.delay_code < req.now_ms) ? req.now_ms : req.delay_code;
        end
    end

    assign wave[0]     = wave_start;
    assign wave_idx[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign left_e[gi] = '0;
                assign left_p[gi] = 1'b0;
            end
            else
            begin : g_mid
                assign left_e[gi] = ent[gi-1];
                assign left_p[gi] = place[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e[gi] = '0;
            end
            else
            begin : g_body
                assign right_e[gi] = ent[gi+1];
            end

            tpts_cell #(
                .QUEUE_DEPTH (QUEUE_DEPTH),
                .INDEX       (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .count        (count_reg),
                .cmd          (cmd),
                .sel_idx      (sel_idx),
                .left_ent     (left_e[gi]),
                .right_ent    (right_e[gi]),
                .left_place   (left_p[gi]),
                .wave_in      (wave[gi]),
                .wave_idx_in  (wave_idx[gi]),
                .ent          (ent[gi]),
                .place        (place[gi]),
                .wave_out     (wave[gi+1]),
                .wave_idx_out (wave_idx[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        due_next       = due_reg;
        prio_next      = prio_reg;
        task_next      = task_reg;
        now_next       = now_reg;
        win_next       = win_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        fin            = 1'b0;
        fin_res        = res_reg;
        sel_idx        = wave_idx[QUEUE_DEPTH];

        cmd.ins             = 1'b0;
        cmd.rmv             = 1'b0;
        cmd.now             = now_reg;
        cmd.new_ent.due     = due_reg;
        cmd.new_ent.prio    = prio_reg;
        cmd.new_ent.task_id = task_reg;

        wave_start       = '0;
        wave_start.open  = win_reg && (count_reg != '0);

        unique case (state_reg)
            tpts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    due_next  = resolved_due;
                    prio_next = req.priority_req;
                    task_next = req.task_id;
                    now_next  = req.now_ms;
                    win_next  = req.in_window;
                    state_next = (req.mode == tpts_pkg::MODE_INSERT) ?
                                 tpts_pkg::ST_INSERT : tpts_pkg::ST_START;
                end
            end
            tpts_pkg::ST_INSERT:
            begin
                fin = 1'b1;
                fin_res.chosen_task = '0;
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    fin_res.status       = tpts_pkg::STAT_FULL;
                    fin_res.entries_held = tpts_pkg::HELD_W'(count_reg);
                end
                else
                begin
                    cmd.ins              = 1'b1;
                    count_next           = count_reg + CW'(1);
                    fin_res.status       = tpts_pkg::STAT_INSERTED;
                    fin_res.entries_held = tpts_pkg::HELD_W'(count_next);
                end
            end
            tpts_pkg::ST_START:
            begin
                wave_start.valid = 1'b1;
                state_next       = tpts_pkg::ST_SCAN;
            end
            tpts_pkg::ST_SCAN:
            begin
                if (wave[QUEUE_DEPTH].valid)
                begin
                    fin = 1'b1;
                    if (wave[QUEUE_DEPTH].found)
                    begin
                        cmd.rmv              = 1'b1;
                        count_next           = count_reg - CW'(1);
                        fin_res.status       = tpts_pkg::STAT_DISPATCHED;
                        fin_res.chosen_task  = wave[QUEUE_DEPTH].task_id;
                        fin_res.entries_held = tpts_pkg::HELD_W'(count_next);
                    end
                    else
                    begin
                        fin_res.status       = tpts_pkg::STAT_IDLE;
                        fin_res.chosen_task  = '0;
                        fin_res.entries_held = tpts_pkg::HELD_W'(count_reg);
                    end
                end
            end
            tpts_pkg::ST_DONE:
            begin
                fin = 1'b1;
            end
            default:
            begin
                state_next = tpts_pkg::ST_IDLE;
            end
        endcase

        if (fin)
        begin
            if (rsp_free)
            begin
                rsp_next       = fin_res;
                rsp_valid_next = 1'b1;
                state_next     = tpts_pkg::ST_IDLE;
            end
            else
            begin
                res_next   = fin_res;
                state_next = tpts_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tpts_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg  <= due_next;
        prio_reg <= prio_next;
        task_reg <= task_next;
        now_reg  <= now_next;
        win_reg  <= win_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds table depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_stall)
        else $error("request taken while previous command still open");

    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != tpts_pkg::STAT_DISPATCHED)) |-> (rsp.chosen_task == '0))
        else $error("task identifier reported without a dispatch");

    a_dispatch_drop: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == tpts_pkg::ST_SCAN) && wave[QUEUE_DEPTH].valid &&
         wave[QUEUE_DEPTH].found) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("dispatch did not remove one entry");

endmodule
